@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl of the thumb store unit
// clocked on i_clk; the first form is switched off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/tsu_pkg.sv @@
// thumb store unit package: command and form codes, sizes, register numbers
// and the register file port structs; no dependencies
`default_nettype none

package tsu_pkg;

    localparam int DATA_W   = 32;
    localparam int RIDX_W   = 4;
    localparam int NUM_REGS = 10;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    localparam logic [3:0] FORM_STMIA    = 4'd0;
    localparam logic [3:0] FORM_STR_IMM  = 4'd1;
    localparam logic [3:0] FORM_STR_REG  = 4'd2;
    localparam logic [3:0] FORM_STR_SP   = 4'd3;
    localparam logic [3:0] FORM_STRB_IMM = 4'd4;
    localparam logic [3:0] FORM_STRB_REG = 4'd5;
    localparam logic [3:0] FORM_STRH_IMM = 4'd6;
    localparam logic [3:0] FORM_STRH_REG = 4'd7;
    localparam logic [3:0] FORM_PUSH     = 4'd8;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [RIDX_W-1:0] REG_SP = 4'd8;
    localparam logic [RIDX_W-1:0] REG_LR = 4'd9;

    typedef struct packed {
        logic              re;
        logic [RIDX_W-1:0] addr;
    } t_rf_rd;

    typedef struct packed {
        logic              we;
        logic [RIDX_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_rf_wr;

    // index of the lowest set bit of a register list
    function automatic logic [2:0] lowest_reg(input logic [7:0] list);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (list[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsu_if.sv @@
// request and response channel interfaces of the thumb store unit
// valid/ready handshake with the payload fields; no dependencies
`default_nettype none

interface tsu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  store_form;
    logic [15:0] instruction_code;
    logic [3:0]  reg_select;
    logic [31:0] reg_value;
    logic [8:0]  abort_mask;

    modport source (
        output valid, command, store_form, instruction_code, reg_select,
               reg_value, abort_mask,
        input  ready
    );
    modport sink (
        input  valid, command, store_form, instruction_code, reg_select,
               reg_value, abort_mask,
        output ready
    );
endinterface

interface tsu_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] address;
    logic [31:0] data;
    logic [1:0]  access_size;
    logic        aborted;
    logic        last;

    modport source (
        output valid, result_kind, address, data, access_size, aborted, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, address, data, access_size, aborted, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/tsu_regfile.sv @@
// register file of r0-r7, sp and lr: one write port, one registered read port
// entries read as zero until first written; uses tsu_pkg
`default_nettype none

module tsu_regfile (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tsu_pkg::t_rf_rd               i_rd,
    input  wire tsu_pkg::t_rf_wr               i_wr,
    output logic [tsu_pkg::DATA_W-1:0]         o_rdata
);

    logic [tsu_pkg::DATA_W-1:0]   r_mem [0:tsu_pkg::NUM_REGS-1];
    logic [tsu_pkg::NUM_REGS-1:0] r_valid;
    logic [tsu_pkg::DATA_W-1:0]   r_rdata;
    logic                         wr_hit;
    logic                         rd_hit;

    assign wr_hit = i_wr.we && (i_wr.addr < tsu_pkg::RIDX_W'(tsu_pkg::NUM_REGS));
    assign rd_hit = i_rd.addr < tsu_pkg::RIDX_W'(tsu_pkg::NUM_REGS);

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_hit) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // unknown register numbers and unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            if (rd_hit && r_valid[i_rd.addr]) begin
                r_rdata <= r_mem[i_rd.addr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/thumb_store_unit_core.sv @@
// thumb store unit top level: sequencer, shared address adder, output register
// uses tsu_pkg, tsu_if, tsu_regfile and assert_macros.svh
`default_nettype none

// Requests write or read r0-r7, sp (8) and lr (9), or execute a Thumb store.
// All register values pass through one read port of the register file, and
// all address arithmetic through one 32-bit adder. A register write gives no
// reply; a register read replies with the value from the registered read
// port. A single STR, STRB or STRH runs base read, offset read, address add,
// then the write request. STMIA and PUSH, after the same setup, issue one
// memory write per cycle while the response channel is ready, up to nine; an
// abort ends the sequence at the refused write with no base or sp update. A
// new request is taken only when the previous one has finished.

`include "assert_macros.svh"

module thumb_store_unit_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsu_in_if.sink     i_req,
    tsu_out_if.source  o_rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REPLY  = 6'b000010,
        S_OPB    = 6'b000100,
        S_OPC    = 6'b001000,
        S_SINGLE = 6'b010000,
        S_MULTI  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [3:0]                 r_form, n_form;
    logic [10:0]                r_code, n_code;
    logic [8:0]                 r_mask, n_mask;
    logic [31:0]                r_base, n_base;
    logic [31:0]                r_addr, n_addr;
    logic [31:0]                r_start, n_start;
    logic [7:0]                 r_list, n_list;
    logic                       r_lr, n_lr;
    logic [3:0]                 r_k, n_k;

    logic                       r_ov, n_ov;
    logic                       r_o_kind, n_o_kind;
    logic [31:0]                r_o_addr, n_o_addr;
    logic [31:0]                r_o_data, n_o_data;
    logic [1:0]                 r_o_size, n_o_size;
    logic                       r_o_ab, n_o_ab;
    logic                       r_o_last, n_o_last;

    tsu_pkg::t_rf_rd            rf_rd;
    tsu_pkg::t_rf_wr            rf_wr;
    logic [31:0]                rf_rdata;

    logic [31:0]                add_a, add_b, add_sum;
    logic                       add_cin;

    logic                       req_acc;
    logic                       o_free;
    logic [4:0]                 imm5;
    logic [3:0]                 push_cnt;
    logic [5:0]                 push_span;
    logic [7:0]                 rest_list;
    logic                       more;
    logic                       mput_ab;
    logic                       mput_last;
    logic                       is_multi;

    tsu_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_rdata (rf_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign o_free      = !r_ov || o_rsp.ready;

    assign imm5      = r_code[10:6];
    assign push_cnt  = 4'($countones(r_code[7:0])) + {3'd0, r_code[8]};
    assign push_span = {push_cnt, 2'b00};
    assign is_multi  = (r_form == tsu_pkg::FORM_STMIA) || (r_form == tsu_pkg::FORM_PUSH);

    // multiple store bookkeeping: current register is the lowest list bit, else lr
    assign rest_list = r_list & (r_list - 8'd1);
    assign more      = (rest_list != 8'd0) || ((r_list != 8'd0) && r_lr);
    assign mput_ab   = r_mask[r_k];
    assign mput_last = mput_ab || !more;

    // shared address adder
    always_comb begin
        add_a   = r_base;
        add_b   = 32'd0;
        add_cin = 1'b0;
        if (r_state == S_MULTI) begin
            add_a = r_addr;
            add_b = 32'd4;
        end else begin
            case (r_form)
                tsu_pkg::FORM_STR_IMM:  add_b = {25'd0, imm5, 2'b00};
                tsu_pkg::FORM_STR_SP:   add_b = {22'd0, r_code[7:0], 2'b00};
                tsu_pkg::FORM_STRB_IMM: add_b = {27'd0, imm5};
                tsu_pkg::FORM_STRH_IMM: add_b = {26'd0, imm5, 1'b0};
                tsu_pkg::FORM_STR_REG,
                tsu_pkg::FORM_STRB_REG,
                tsu_pkg::FORM_STRH_REG: add_b = rf_rdata;
                tsu_pkg::FORM_PUSH: begin
                    add_b   = ~{26'd0, push_span};
                    add_cin = 1'b1;
                end
                default:                add_b = 32'd0;
            endcase
        end
        add_sum = add_a + add_b + {31'd0, add_cin};
    end

    always_comb begin
        n_state   = r_state;
        n_form    = r_form;
        n_code    = r_code;
        n_mask    = r_mask;
        n_base    = r_base;
        n_addr    = r_addr;
        n_start   = r_start;
        n_list    = r_list;
        n_lr      = r_lr;
        n_k       = r_k;
        n_ov      = r_ov && !o_rsp.ready;
        n_o_kind  = r_o_kind;
        n_o_addr  = r_o_addr;
        n_o_data  = r_o_data;
        n_o_size  = r_o_size;
        n_o_ab    = r_o_ab;
        n_o_last  = r_o_last;
        rf_rd     = '{re: 1'b0, addr: tsu_pkg::RIDX_W'(0)};
        rf_wr     = '{we: 1'b0, addr: tsu_pkg::RIDX_W'(0), data: 32'd0};

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_form = i_req.store_form;
                    n_code = i_req.instruction_code[10:0];
                    n_mask = i_req.abort_mask;
                    case (i_req.command)
                        tsu_pkg::CMD_WRITE: begin
                            rf_wr = '{we: 1'b1, addr: i_req.reg_select,
                                      data: i_req.reg_value};
                        end
                        tsu_pkg::CMD_READ: begin
                            rf_rd   = '{re: 1'b1, addr: i_req.reg_select};
                            n_state = S_REPLY;
                        end
                        tsu_pkg::CMD_EXEC: begin
                            if (i_req.store_form <= tsu_pkg::FORM_PUSH) begin
                                rf_rd.re = 1'b1;
                                if (i_req.store_form == tsu_pkg::FORM_STMIA) begin
                                    rf_rd.addr = {1'b0, i_req.instruction_code[10:8]};
                                end else if (i_req.store_form inside
                                             {tsu_pkg::FORM_STR_SP, tsu_pkg::FORM_PUSH}) begin
                                    rf_rd.addr = tsu_pkg::REG_SP;
                                end else begin
                                    rf_rd.addr = {1'b0, i_req.instruction_code[5:3]};
                                end
                                n_state = S_OPB;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_REPLY: begin
                if (o_free) begin
                    n_ov     = 1'b1;
                    n_o_kind = tsu_pkg::KIND_READ;
                    n_o_addr = 32'd0;
                    n_o_data = rf_rdata;
                    n_o_size = tsu_pkg::SIZE_WORD;
                    n_o_ab   = 1'b0;
                    n_o_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_OPB: begin
                n_base  = rf_rdata;
                rf_rd   = '{re: 1'b1, addr: {1'b0, r_code[8:6]}};
                n_state = S_OPC;
            end

            S_OPC: begin
                n_addr  = add_sum;
                n_start = add_sum;
                n_list  = r_code[7:0];
                n_lr    = (r_form == tsu_pkg::FORM_PUSH) && r_code[8];
                n_k     = 4'd0;
                if (is_multi) begin
                    if ((r_code[7:0] == 8'd0) && !n_lr) begin
                        n_state = S_IDLE;
                    end else begin
                        rf_rd.re   = 1'b1;
                        rf_rd.addr = (r_code[7:0] != 8'd0)
                                   ? {1'b0, tsu_pkg::lowest_reg(r_code[7:0])}
                                   : tsu_pkg::REG_LR;
                        n_state    = S_MULTI;
                    end
                end else begin
                    rf_rd.re   = 1'b1;
                    rf_rd.addr = (r_form == tsu_pkg::FORM_STR_SP) ? {1'b0, r_code[10:8]}
                                                                   : {1'b0, r_code[2:0]};
                    n_state    = S_SINGLE;
                end
            end

            S_SINGLE: begin
                if (o_free) begin
                    n_ov     = 1'b1;
                    n_o_kind = tsu_pkg::KIND_WRITE;
                    n_o_addr = r_addr;
                    n_o_ab   = r_mask[0];
                    n_o_last = 1'b1;
                    if (r_form inside {tsu_pkg::FORM_STRB_IMM, tsu_pkg::FORM_STRB_REG}) begin
                        n_o_size = tsu_pkg::SIZE_BYTE;
                        n_o_data = {24'd0, rf_rdata[7:0]};
                    end else if (r_form inside
                                 {tsu_pkg::FORM_STRH_IMM, tsu_pkg::FORM_STRH_REG}) begin
                        n_o_size = tsu_pkg::SIZE_HALF;
                        n_o_data = r_addr[0] ? 32'd0 : {16'd0, rf_rdata[15:0]};
                    end else begin
                        n_o_size = tsu_pkg::SIZE_WORD;
                        n_o_data = (r_addr[1:0] != 2'b00) ? 32'd0 : rf_rdata;
                    end
                    n_state = S_IDLE;
                end
            end

            S_MULTI: begin
                if (o_free) begin
                    n_ov     = 1'b1;
                    n_o_kind = tsu_pkg::KIND_WRITE;
                    n_o_addr = r_addr;
                    n_o_data = rf_rdata;
                    n_o_size = tsu_pkg::SIZE_WORD;
                    n_o_ab   = mput_ab;
                    n_o_last = mput_last;
                    n_addr   = add_sum;
                    n_k      = r_k + 4'd1;
                    if (r_list != 8'd0) begin
                        n_list = rest_list;
                    end else begin
                        n_lr = 1'b0;
                    end
                    if (mput_last) begin
                        // base or sp written back only when no write was refused
                        if (!mput_ab) begin
                            rf_wr.we = 1'b1;
                            if (r_form == tsu_pkg::FORM_PUSH) begin
                                rf_wr.addr = tsu_pkg::REG_SP;
                                rf_wr.data = r_start;
                            end else begin
                                rf_wr.addr = {1'b0, r_code[10:8]};
                                rf_wr.data = add_sum;
                            end
                        end
                        n_state = S_IDLE;
                    end else begin
                        rf_rd.re   = 1'b1;
                        rf_rd.addr = (rest_list != 8'd0)
                                   ? {1'b0, tsu_pkg::lowest_reg(rest_list)}
                                   : tsu_pkg::REG_LR;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_form   <= n_form;
        r_code   <= n_code;
        r_mask   <= n_mask;
        r_base   <= n_base;
        r_addr   <= n_addr;
        r_start  <= n_start;
        r_list   <= n_list;
        r_lr     <= n_lr;
        r_k      <= n_k;
        r_o_kind <= n_o_kind;
        r_o_addr <= n_o_addr;
        r_o_data <= n_o_data;
        r_o_size <= n_o_size;
        r_o_ab   <= n_o_ab;
        r_o_last <= n_o_last;
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.result_kind = r_o_kind;
    assign o_rsp.address     = r_o_addr;
    assign o_rsp.data        = r_o_data;
    assign o_rsp.access_size = r_o_size;
    assign o_rsp.aborted     = r_o_ab;
    assign o_rsp.last        = r_o_last;

    `ASSERT_ANY(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE) && !r_ov, "reset not taken")
    `ASSERT_CLKD(a_k_range, (r_state == S_MULTI) |-> (r_k <= 4'd8), "write count past nine")
    `ASSERT_CLKD(a_multi_work, (r_state == S_MULTI) |-> ((r_list != 8'd0) || r_lr), "no register left")
    `ASSERT_CLKD(a_multi_end, (r_state == S_MULTI) && o_free && mput_last |=> (r_state == S_IDLE), "store did not end")
    `ASSERT_CLKD(a_abort_last, r_ov && r_o_ab |-> r_o_last, "aborted write not last")

endmodule

`default_nettype wire
